>>> src/tria_pkg.sv
// Shared constants and types for the two-resource interval assigner.
`default_nettype none
package tria_pkg;

  localparam int MAX_ACT   = 64;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_ACT);
  localparam int CNT_W     = IDX_W + 1;
  localparam int FIELD_W   = 16;
  localparam int OUT_IDX_W = 6;
  localparam int WORD_W    = 2 * TIME_BITS;
  localparam int KEY_W     = TIME_BITS + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_STEP,
    S_EMIT,
    S_FAIL
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic step_en;
    logic emit_en;
    logic fail_en;
    logic run_clr;
  } ctrl_t;

endpackage
`default_nettype wire

>>> src/tria_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tria_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> src/two_resource_interval_assigner_top.sv
// Top level of the two-resource interval assigner.
//
// Input channel: a word (start_time_i, end_time_i, last_activity_i) is taken
// at a rising edge with start high and busy low. While loading, one word is
// taken per cycle and written to the activity RAM in arrival order; words past
// the 64-entry capacity are dropped and mark the run as impossible.
// After the word with last_activity_i set, busy stays high while the run is
// solved. The shared compare unit walks the RAM once per activity to pick the
// next one in (start time, arrival) order, then applies one greedy step to the
// two worker free-at times. Each of the n passes for a run of n activities
// reads every stored word through the single RAM read port.
// Results follow one per cycle, n in all, in arrival order, each marked by
// result_strobe_o for exactly one cycle; a failed run gives one impossible
// result instead. busy drops with the last result, and the next word may be
// taken in that same cycle. The receiver cannot stall the results.
// Reset clears the run count, the overflow mark and the state machine; the
// RAM contents are not cleared and are only read after being written.
`default_nettype none
module two_resource_interval_assigner_top
  import tria_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [FIELD_W-1:0]   start_time_i,
  input  wire logic [FIELD_W-1:0]   end_time_i,
  input  wire logic                 last_activity_i,
  output      logic                 result_strobe_o,
  output      logic [OUT_IDX_W-1:0] activity_index_o,
  output      logic                 worker_o,
  output      logic                 impossible_o,
  output      logic                 last_result_o
);

  state_e state_q, state_d;
  ctrl_t  ctrl;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [IDX_W-1:0]   pass_q, pass_d;
  logic [IDX_W-1:0]   emit_q, emit_d;
  logic               found_q, found_d;
  logic [KEY_W-1:0]   best_key_q, best_key_d;
  logic [TIME_BITS-1:0] best_end_q, best_end_d;
  logic [KEY_W-1:0]   prev_key_q, prev_key_d;
  logic [TIME_BITS-1:0] free0_q, free0_d, free1_q, free1_d;
  logic [MAX_ACT-1:0] bits_q, bits_d;

  logic                 strobe_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 out_worker_q, out_imp_q, out_last_q;

  logic                 accept, full, we;
  logic [WORD_W-1:0]    wdata, rdata;
  logic [TIME_BITS-1:0] rd_start, rd_end, best_start;
  logic [IDX_W-1:0]     best_idx;
  logic [KEY_W-1:0]     cand_key;
  logic                 cand_after_prev, cand_better, scan_done;
  logic                 last_pass, last_emit, step_fail;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt_q == CNT_W'(MAX_ACT));
  assign we     = accept && !full;
  assign wdata  = {start_time_i[TIME_BITS-1:0], end_time_i[TIME_BITS-1:0]};

  tria_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ACT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (ctrl.rd_en),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign rd_start   = rdata[WORD_W-1:TIME_BITS];
  assign rd_end     = rdata[TIME_BITS-1:0];
  assign cand_key   = {rd_start, rd_idx_q};
  assign best_start = best_key_q[KEY_W-1:IDX_W];
  assign best_idx   = best_key_q[IDX_W-1:0];

  // shared compare unit: candidate must follow the previous pick in
  // (start, arrival) order and precede the current best
  assign cand_after_prev = (pass_q == '0) || (cand_key > prev_key_q);
  assign cand_better     = !found_q || (cand_key < best_key_q);
  assign scan_done       = (rd_cnt_q == cnt_q) && !rd_vld_q;

  assign last_pass = ({1'b0, pass_q} + CNT_W'(1)) == cnt_q;
  assign last_emit = ({1'b0, emit_q} + CNT_W'(1)) == cnt_q;
  assign step_fail = (pass_q > IDX_W'(1)) && (best_start < free0_q)
                     && (best_start < free1_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && last_activity_i) begin
          state_d = (ovf_q || full) ? S_FAIL : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) state_d = S_STEP;
      end
      S_STEP: begin
        if (step_fail)      state_d = S_FAIL;
        else if (last_pass) state_d = S_EMIT;
        else                state_d = S_SCAN;
      end
      S_EMIT: begin
        if (last_emit) state_d = S_IDLE;
      end
      S_FAIL:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    ctrl = '0;
    case (state_q)
      S_SCAN:  ctrl.rd_en   = (rd_cnt_q != cnt_q);
      S_STEP:  ctrl.step_en = 1'b1;
      S_EMIT: begin
        ctrl.emit_en = 1'b1;
        ctrl.run_clr = last_emit;
      end
      S_FAIL: begin
        ctrl.fail_en = 1'b1;
        ctrl.run_clr = 1'b1;
      end
      default: ctrl = '0;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    pass_d     = pass_q;
    emit_d     = emit_q;
    found_d    = found_q;
    best_key_d = best_key_q;
    best_end_d = best_end_q;
    prev_key_d = prev_key_q;
    free0_d    = free0_q;
    free1_d    = free1_q;
    bits_d     = bits_q;

    if (accept) begin
      if (full) ovf_d = 1'b1;
      else      cnt_d = cnt_q + CNT_W'(1);
      if (last_activity_i) begin
        rd_cnt_d = '0;
        pass_d   = '0;
        emit_d   = '0;
        found_d  = 1'b0;
      end
    end

    if (ctrl.rd_en) begin
      rd_cnt_d = rd_cnt_q + CNT_W'(1);
      rd_vld_d = 1'b1;
    end

    if (rd_vld_q && cand_after_prev && cand_better) begin
      found_d    = 1'b1;
      best_key_d = cand_key;
      best_end_d = rd_end;
    end

    if (ctrl.step_en) begin
      prev_key_d = best_key_q;
      pass_d     = pass_q + IDX_W'(1);
      rd_cnt_d   = '0;
      found_d    = 1'b0;
      if (pass_q == '0) begin
        free0_d = best_end_q;
        bits_d  = '0;
      end else if (pass_q == IDX_W'(1)) begin
        free1_d          = best_end_q;
        bits_d[best_idx] = 1'b1;
      end else if (best_start >= free0_q) begin
        free0_d = best_end_q;
      end else if (best_start >= free1_q) begin
        free1_d          = best_end_q;
        bits_d[best_idx] = 1'b1;
      end
    end

    if (ctrl.emit_en) emit_d = emit_q + IDX_W'(1);

    if (ctrl.run_clr) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      pass_q   <= '0;
      emit_q   <= '0;
      found_q  <= 1'b0;
      free0_q  <= '0;
      free1_q  <= '0;
      bits_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      rd_cnt_q <= rd_cnt_d;
      rd_vld_q <= rd_vld_d;
      pass_q   <= pass_d;
      emit_q   <= emit_d;
      found_q  <= found_d;
      free0_q  <= free0_d;
      free1_q  <= free1_d;
      bits_q   <= bits_d;
      strobe_q <= ctrl.emit_en || ctrl.fail_en;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_cnt_q[IDX_W-1:0];
    best_key_q <= best_key_d;
    best_end_q <= best_end_d;
    prev_key_q <= prev_key_d;
    if (ctrl.fail_en) begin
      out_idx_q    <= '0;
      out_worker_q <= 1'b0;
      out_imp_q    <= 1'b1;
      out_last_q   <= 1'b1;
    end else if (ctrl.emit_en) begin
      out_idx_q    <= emit_q;
      out_worker_q <= bits_q[emit_q];
      out_imp_q    <= 1'b0;
      out_last_q   <= last_emit;
    end
  end

  assign result_strobe_o  = strobe_q;
  assign activity_index_o = OUT_IDX_W'(out_idx_q);
  assign worker_o         = out_worker_q;
  assign impossible_o     = out_imp_q;
  assign last_result_o    = out_last_q;

endmodule
`default_nettype wire

>>> src/tria_checker.sv
// Port-level checks for the interval assigner, bound to the top level.
`default_nettype none
module tria_checker
  import tria_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 last_activity_i,
  input wire logic                 result_strobe_o,
  input wire logic [OUT_IDX_W-1:0] activity_index_o,
  input wire logic                 worker_o,
  input wire logic                 impossible_o,
  input wire logic                 last_result_o
);

  // impossible word is the final, fixed-form result of its run
  a_imp_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && impossible_o |->
      last_result_o && !worker_o && (activity_index_o == '0))
    else $error("impossible word malformed");

  // results of one run come out back to back
  a_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_result_o |=> result_strobe_o)
    else $error("gap inside result burst");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_result_o |=> !result_strobe_o)
    else $error("word after final result");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_activity_i |=> !result_strobe_o && !busy)
    else $error("activity load not quiet");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_activity_i |=> busy)
    else $error("busy missing after final activity");

endmodule

bind two_resource_interval_assigner_top tria_checker u_tria_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .last_activity_i  (last_activity_i),
  .result_strobe_o  (result_strobe_o),
  .activity_index_o (activity_index_o),
  .worker_o         (worker_o),
  .impossible_o     (impossible_o),
  .last_result_o    (last_result_o)
);
`default_nettype wire
